@@ hw/rtl/png_cp_pkg.sv @@
// Shared types, codes and lookup functions for the PNG chunk stream parser.
package png_cp_pkg;

    // Width of the chunk length and byte position counters
    localparam int CNT_W = 31;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CRC,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // Chunk kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_IHDR  = 2'd1;
    localparam logic [1:0] KIND_IDAT  = 2'd2;
    localparam logic [1:0] KIND_IEND  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE   = 3'd1;
    localparam logic [2:0] ERR_COLOR_DEPTH = 3'd2;
    localparam logic [2:0] ERR_COMPRESSION = 3'd3;
    localparam logic [2:0] ERR_FILTER      = 3'd4;
    localparam logic [2:0] ERR_INTERLACE   = 3'd5;

    // Parse status codes
    localparam logic [1:0] STAT_BUSY  = 2'd0;
    localparam logic [1:0] STAT_END   = 2'd1;
    localparam logic [1:0] STAT_ERROR = 2'd2;

    // Chunk type words
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Byte positions inside the IHDR payload
    localparam logic [CNT_W-1:0] IHDR_WIDTH_LAST  = CNT_W'(3);
    localparam logic [CNT_W-1:0] IHDR_HEIGHT_LAST = CNT_W'(7);
    localparam logic [CNT_W-1:0] IHDR_DEPTH       = CNT_W'(8);
    localparam logic [CNT_W-1:0] IHDR_COLOR       = CNT_W'(9);
    localparam logic [CNT_W-1:0] IHDR_COMPRESSION = CNT_W'(10);
    localparam logic [CNT_W-1:0] IHDR_FILTER      = CNT_W'(11);
    localparam logic [CNT_W-1:0] IHDR_INTERLACE   = CNT_W'(12);

    // Last byte of a four-byte field
    localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(3);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [2:0]  error_kind;
        logic [1:0]  chunk_kind;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        header_valid;
        logic [30:0] image_width;
        logic [30:0] image_height;
        logic [7:0]  sample_depth;
        logic [7:0]  color_kind;
        logic        interlaced;
    } out_item_t;

    // File signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0: val = 8'h89;
            3'd1: val = 8'h50;
            3'd2: val = 8'h4E;
            3'd3: val = 8'h47;
            3'd4: val = 8'h0D;
            3'd5: val = 8'h0A;
            3'd6: val = 8'h1A;
            3'd7: val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Allowed bit depths per color type
    function automatic logic depth_fits_color(input logic [7:0] color, input logic [7:0] depth);
        logic ok;
        case (color) inside
            8'd0: ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                       (depth == 8'd8) || (depth == 8'd16);
            8'd3: ok = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                       (depth == 8'd8);
            8'd2, 8'd4, 8'd6: ok = (depth == 8'd8) || (depth == 8'd16);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ hw/rtl/png_cp_in_reg.sv @@
// Input register: holds one accepted byte item until the parse step takes it.
module png_cp_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  png_cp_pkg::in_item_t item,
    input  logic                 take,
    output logic                 hold_valid,
    output png_cp_pkg::in_item_t hold_item
);
    import png_cp_pkg::*;

    logic     full_reg;
    logic     full_next;
    in_item_t item_reg;
    logic     accept;

    // Refuse a new item only while the held one cannot move on
    assign stall  = full_reg && !take;
    assign accept = valid && !stall;

    // Track occupancy
    always_comb
    begin
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign hold_valid = full_reg;
    assign hold_item  = item_reg;

    // A held item that is not taken stays held
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !take |=> full_reg)
        else $error("held item lost without being taken");

endmodule

@@ hw/rtl/png_cp_step.sv @@
// Parse step: parser state registers and the per-byte next-state logic.
module png_cp_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  png_cp_pkg::in_item_t  item,
    output png_cp_pkg::out_item_t result
);
    import png_cp_pkg::*;

    phase_t           phase_reg,  phase_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [31:0]      shift_reg,  shift_next;
    logic [CNT_W-1:0] len_reg,    len_next;
    logic [1:0]       kind_reg,   kind_next;
    logic [30:0]      width_reg,  width_next;
    logic [30:0]      height_reg, height_next;
    logic [7:0]       depth_reg,  depth_next;
    logic [7:0]       color_reg,  color_next;
    logic             ilace_reg,  ilace_next;
    logic             hdr_reg,    hdr_next;
    logic [2:0]       err_reg,    err_next;

    phase_t           cur_phase;
    logic [CNT_W-1:0] cur_cnt;
    logic [31:0]      cur_shift;
    logic [CNT_W-1:0] cur_len;
    logic [1:0]       cur_kind;
    logic [30:0]      cur_width;
    logic [30:0]      cur_height;
    logic [7:0]       cur_depth;
    logic [7:0]       cur_color;
    logic             cur_ilace;
    logic             cur_hdr;
    logic [2:0]       cur_err;

    logic [7:0]       b;
    logic [31:0]      shift_in;
    logic [CNT_W-1:0] cnt_inc;
    logic             word_end;
    logic [1:0]       typed_kind;
    logic [2:0]       err_code;
    logic             pv;

    assign b = item.data_byte;

    // Start of file clears the state before this byte is parsed
    always_comb
    begin
        if (item.start_of_file)
        begin
            cur_phase  = PH_SIG;
            cur_cnt    = '0;
            cur_shift  = '0;
            cur_len    = '0;
            cur_kind   = KIND_OTHER;
            cur_width  = '0;
            cur_height = '0;
            cur_depth  = '0;
            cur_color  = '0;
            cur_ilace  = 1'b0;
            cur_hdr    = 1'b0;
            cur_err    = ERR_NONE;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_cnt    = cnt_reg;
            cur_shift  = shift_reg;
            cur_len    = len_reg;
            cur_kind   = kind_reg;
            cur_width  = width_reg;
            cur_height = height_reg;
            cur_depth  = depth_reg;
            cur_color  = color_reg;
            cur_ilace  = ilace_reg;
            cur_hdr    = hdr_reg;
            cur_err    = err_reg;
        end
    end

    assign shift_in = {cur_shift[23:0], b};
    assign cnt_inc  = cur_cnt + CNT_W'(1);
    assign word_end = (cur_cnt == WORD_LAST);

    // Classify the chunk type word
    always_comb
    begin
        if (shift_in == TYPE_IHDR)
        begin
            typed_kind = KIND_IHDR;
        end
        else if (shift_in == TYPE_IDAT)
        begin
            typed_kind = KIND_IDAT;
        end
        else if (shift_in == TYPE_IEND)
        begin
            typed_kind = KIND_IEND;
        end
        else
        begin
            typed_kind = KIND_OTHER;
        end
    end

    // Detect signature and header field errors
    always_comb
    begin
        err_code = ERR_NONE;
        if (cur_phase == PH_SIG)
        begin
            if (b != sig_byte(cur_cnt[2:0]))
            begin
                err_code = ERR_SIGNATURE;
            end
        end
        else if (cur_phase == PH_PAYLOAD && cur_kind == KIND_IHDR)
        begin
            if (cur_cnt == IHDR_COLOR && !depth_fits_color(b, cur_depth))
            begin
                err_code = ERR_COLOR_DEPTH;
            end
            else if (cur_cnt == IHDR_COMPRESSION && b != 8'd0)
            begin
                err_code = ERR_COMPRESSION;
            end
            else if (cur_cnt == IHDR_FILTER && b != 8'd0)
            begin
                err_code = ERR_FILTER;
            end
            else if (cur_cnt == IHDR_INTERLACE && b > 8'd1)
            begin
                err_code = ERR_INTERLACE;
            end
        end
    end

    // Next phase
    always_comb
    begin
        unique case (cur_phase)
            PH_SIG:
            begin
                if (err_code != ERR_NONE)
                begin
                    phase_next = PH_ERROR;
                end
                else if (cur_cnt[2:0] == 3'd7)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_SIG;
                end
            end
            PH_LEN:
            begin
                phase_next = word_end ? PH_TYPE : PH_LEN;
            end
            PH_TYPE:
            begin
                if (!word_end)
                begin
                    phase_next = PH_TYPE;
                end
                else if (typed_kind == KIND_IEND)
                begin
                    phase_next = PH_DONE;
                end
                else if (cur_len == '0)
                begin
                    phase_next = PH_CRC;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (err_code != ERR_NONE)
                begin
                    phase_next = PH_ERROR;
                end
                else if (cnt_inc == cur_len)
                begin
                    phase_next = PH_CRC;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_CRC:
            begin
                phase_next = word_end ? PH_LEN : PH_CRC;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            PH_ERROR:
            begin
                phase_next = PH_ERROR;
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // Counters, shifter and captured header fields
    always_comb
    begin
        cnt_next    = cur_cnt;
        shift_next  = cur_shift;
        len_next    = cur_len;
        kind_next   = cur_kind;
        width_next  = cur_width;
        height_next = cur_height;
        depth_next  = cur_depth;
        color_next  = cur_color;
        ilace_next  = cur_ilace;
        hdr_next    = cur_hdr;
        err_next    = (err_code != ERR_NONE) ? err_code : cur_err;
        pv          = 1'b0;
        unique case (cur_phase)
            PH_SIG:
            begin
                if (err_code == ERR_NONE)
                begin
                    if (cur_cnt[2:0] == 3'd7)
                    begin
                        cnt_next   = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            PH_LEN:
            begin
                if (word_end)
                begin
                    len_next   = shift_in[CNT_W-1:0];
                    cnt_next   = '0;
                    shift_next = '0;
                end
                else
                begin
                    shift_next = shift_in;
                    cnt_next   = cnt_inc;
                end
            end
            PH_TYPE:
            begin
                if (word_end)
                begin
                    kind_next  = typed_kind;
                    cnt_next   = '0;
                    shift_next = '0;
                    if (typed_kind == KIND_IHDR)
                    begin
                        hdr_next = 1'b0;
                    end
                end
                else
                begin
                    shift_next = shift_in;
                    cnt_next   = cnt_inc;
                end
            end
            PH_PAYLOAD:
            begin
                if (cur_kind == KIND_IHDR)
                begin
                    if (cur_cnt < IHDR_DEPTH)
                    begin
                        shift_next = shift_in;
                    end
                    if (cur_cnt == IHDR_WIDTH_LAST)
                    begin
                        width_next = shift_in[30:0];
                    end
                    if (cur_cnt == IHDR_HEIGHT_LAST)
                    begin
                        height_next = shift_in[30:0];
                    end
                    if (cur_cnt == IHDR_DEPTH)
                    begin
                        depth_next = b;
                    end
                    if (cur_cnt == IHDR_COLOR)
                    begin
                        color_next = b;
                    end
                    if (cur_cnt == IHDR_INTERLACE && b <= 8'd1)
                    begin
                        ilace_next = b[0];
                        hdr_next   = 1'b1;
                    end
                end
                if (err_code == ERR_NONE)
                begin
                    pv       = 1'b1;
                    cnt_next = (cnt_inc == cur_len) ? '0 : cnt_inc;
                end
            end
            PH_CRC:
            begin
                if (word_end)
                begin
                    cnt_next   = '0;
                    shift_next = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                pv = 1'b0;
            end
        endcase
    end

    // Result for this byte, showing the state after it
    always_comb
    begin
        if (phase_next == PH_ERROR)
        begin
            result.parse_status = STAT_ERROR;
        end
        else if (phase_next == PH_DONE)
        begin
            result.parse_status = STAT_END;
        end
        else
        begin
            result.parse_status = STAT_BUSY;
        end
        result.error_kind    = err_next;
        result.chunk_kind    = kind_next;
        result.payload_valid = pv;
        result.payload_byte  = pv ? b : 8'd0;
        result.header_valid  = hdr_next;
        result.image_width   = width_next;
        result.image_height  = height_next;
        result.sample_depth  = depth_next;
        result.color_kind    = color_next;
        result.interlaced    = ilace_next;
    end

    // Advance the parser state on each item taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            cnt_reg    <= '0;
            shift_reg  <= '0;
            len_reg    <= '0;
            kind_reg   <= KIND_OTHER;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            color_reg  <= '0;
            ilace_reg  <= 1'b0;
            hdr_reg    <= 1'b0;
            err_reg    <= ERR_NONE;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            color_reg  <= color_next;
            ilace_reg  <= ilace_next;
            hdr_reg    <= hdr_next;
            err_reg    <= err_next;
        end
    end

    // An error code is latched exactly while in the error phase
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) == (err_reg != ERR_NONE))
        else $error("error code and error phase disagree");

    // A failed parse never shows a valid header
    a_err_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> !hdr_reg)
        else $error("header valid during error");

    // Only a new file leaves the error phase
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR && !(advance && item.start_of_file) |=> phase_reg == PH_ERROR)
        else $error("error phase left without start of file");

endmodule

@@ hw/rtl/png_cp_out_reg.sv @@
// Result register: holds one result item until the receiver takes it.
module png_cp_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  png_cp_pkg::out_item_t result,
    output logic                  free,
    output logic                  valid,
    input  logic                  stall,
    output png_cp_pkg::out_item_t item
);
    import png_cp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Room for a new result when empty or when the current one leaves now
    assign free       = !valid_reg || !stall;
    assign valid_next = load || (valid_reg && stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

    // Never overwrite a result still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && stall))
        else $error("result overwritten while stalled");

endmodule

@@ hw/rtl/png_chunk_stream_parser.sv @@
// Top level of the PNG chunk stream parser: input register, parse step, result register.
//
//  Channel   Signals                                   Direction  Moves
//  byte      byte_valid, byte_stall, byte_item         in         one file byte per item
//  result    result_valid, result_stall, result_item   out        one parse result per item
//
//  Each byte item yields one result item; one item per cycle is sustained while result_stall is low.
//  Each item passes the input register, then the result register.
//  The parse step is one short combinational pass between those registers.
//  rst_n clears all parser state asynchronously; start_of_file does the same per file.
//  A stall on the result side backs up through the input register into byte_stall.
module png_chunk_stream_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  png_cp_pkg::in_item_t  byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output png_cp_pkg::out_item_t result_item
);
    import png_cp_pkg::*;

    logic      hold_valid;
    in_item_t  hold_item;
    logic      out_free;
    logic      advance;
    out_item_t step_result;

    // Move the held byte through the step when the result register has room
    assign advance = hold_valid && out_free;

    png_cp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (byte_valid),
        .stall      (byte_stall),
        .item       (byte_item),
        .take       (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    png_cp_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (hold_item),
        .result  (step_result)
    );

    png_cp_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (step_result),
        .free   (out_free),
        .valid  (result_valid),
        .stall  (result_stall),
        .item   (result_item)
    );

endmodule
